// ===== rtl/afa_pkg.sv =====
// Shared types and constants of the flap actuator controller.
package afa_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned TickW    = 16;
	localparam int unsigned MsW      = 20;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_OPEN_SPEED    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CLOSE_SPEED   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_OPEN_ANGLE    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CLOSE_ANGLE   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SETTLE_TIME   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_INPUT_TIMEOUT = 3'd5;

	// Event codes
	localparam logic [2:0] MODE_TICK        = 3'd0;
	localparam logic [2:0] MODE_SNAPSHOT    = 3'd1;
	localparam logic [2:0] MODE_SERVO       = 3'd2;
	localparam logic [2:0] MODE_FORCE_CLOSE = 3'd3;
	localparam logic [2:0] MODE_DISABLE     = 3'd4;
	localparam logic [2:0] MODE_CLEAR       = 3'd5;

	// Fault bit positions
	localparam int unsigned FLT_TIMEOUT  = 0;
	localparam int unsigned FLT_DISABLED = 1;
	localparam int unsigned FLT_SERVO    = 2;

	// Phase codes as seen on fsm_state
	localparam logic [1:0] PH_CLOSED  = 2'd0;
	localparam logic [1:0] PH_OPENING = 2'd1;
	localparam logic [1:0] PH_OPEN    = 2'd2;
	localparam logic [1:0] PH_CLOSING = 2'd3;

	typedef struct packed {
		logic [7:0]       open_speed;
		logic [7:0]       close_speed;
		logic [7:0]       open_angle;
		logic [7:0]       close_angle;
		logic [TickW-1:0] settle_time_ms;
		logic [TickW-1:0] snap_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] veh_speed;
		logic       brake_on;
		logic       enable_in;
		logic       external_fault_in;
		logic       servo_reached;
	} item_t;

	typedef struct packed {
		logic       open_cmd;
		logic       close_cmd;
		logic [7:0] target_angle;
		logic [2:0] fault_latch;
		logic [1:0] fsm_state;
	} result_t;

endpackage

// ===== rtl/afa_cfg.sv =====
// Configuration register file of the flap actuator controller.
module afa_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [afa_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [afa_pkg::CfgDataW-1:0]  cfg_data,
	output afa_pkg::cfg_t                 cfg
);
	import afa_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OPEN_SPEED:    cfg_q.open_speed      <= cfg_data[7:0];
				REG_CLOSE_SPEED:   cfg_q.close_speed     <= cfg_data[7:0];
				REG_OPEN_ANGLE:    cfg_q.open_angle      <= cfg_data[7:0];
				REG_CLOSE_ANGLE:   cfg_q.close_angle     <= cfg_data[7:0];
				REG_SETTLE_TIME:   cfg_q.settle_time_ms  <= cfg_data[TickW-1:0];
				REG_INPUT_TIMEOUT: cfg_q.snap_timeout_ms <= cfg_data[TickW-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/afa_core.sv =====
// Phase machine, tick counters, fault bits and latched result record.
module afa_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  afa_pkg::item_t  item,
	input  afa_pkg::cfg_t   cfg,
	output afa_pkg::result_t res
);
	import afa_pkg::*;

	typedef enum logic [1:0] {
		CLOSED  = PH_CLOSED,
		OPENING = PH_OPENING,
		OPEN    = PH_OPEN,
		CLOSING = PH_CLOSING
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [TickW-1:0] tip_q, tip_d, tss_q, tss_d;
	logic [2:0]       fault_q, fault_d;
	logic             servo_done_q, servo_done_d;
	logic [7:0]       speed_q, speed_d;
	logic             brake_q, brake_d, enable_q, enable_d, ext_q, ext_d;
	logic             open_q, open_d, close_q, close_d;
	logic [7:0]       angle_q, angle_d;
	logic [2:0]       flags_q, flags_d;

	logic [TickW-1:0] tip_inc, tss_inc;
	logic [MsW-1:0]   ms_tip, ms_tss, wd_limit;
	logic             must_close, leave_low, entered;

	// Saturating counters and their elapsed time in ms (x10 as shift-add)
	always_comb begin
		tip_inc  = (tip_q == '1) ? tip_q : tip_q + 1'b1;
		tss_inc  = (tss_q == '1) ? tss_q : tss_q + 1'b1;
		ms_tip   = {1'b0, tip_inc, 3'b000} + {3'b000, tip_inc, 1'b0};
		ms_tss   = {1'b0, tss_inc, 3'b000} + {3'b000, tss_inc, 1'b0};
		wd_limit = {4'b0000, cfg.settle_time_ms[TickW-2:0], 1'b0};
	end

	always_comb begin
		phase_d      = phase_q;
		tip_d        = tip_q;
		tss_d        = tss_q;
		fault_d      = fault_q;
		servo_done_d = servo_done_q;
		speed_d      = speed_q;
		brake_d      = brake_q;
		enable_d     = enable_q;
		ext_d        = ext_q;
		open_d       = open_q;
		close_d      = close_q;
		angle_d      = angle_q;
		flags_d      = flags_q;
		must_close   = 1'b0;
		leave_low    = 1'b0;
		entered      = 1'b0;
		if (go) begin
			case (item.mode)
				MODE_TICK: begin
					open_d  = 1'b0;
					close_d = 1'b0;
					tip_d   = tip_inc;
					tss_d   = tss_inc;
					fault_d[FLT_TIMEOUT]  = ms_tss > {4'b0000, cfg.snap_timeout_ms};
					fault_d[FLT_DISABLED] = !enable_q;
					must_close = fault_d[FLT_TIMEOUT] || fault_d[FLT_DISABLED] || ext_q;
					leave_low  = must_close || brake_q || (speed_q < cfg.close_speed);
					case (phase_q)
						CLOSED: begin
							if (!must_close && !brake_q && speed_q > cfg.open_speed) begin
								open_d  = 1'b1;
								angle_d = cfg.open_angle;
								phase_d = OPENING;
								tip_d   = '0;
								entered = 1'b1;
							end
						end
						OPENING: begin
							if (leave_low) begin
								close_d = 1'b1;
								angle_d = cfg.close_angle;
								phase_d = CLOSING;
								tip_d   = '0;
								entered = 1'b1;
							end else if (servo_done_q ||
							             ms_tip >= {4'b0000, cfg.settle_time_ms}) begin
								phase_d = OPEN;
								tip_d   = '0;
								entered = 1'b1;
							end
						end
						OPEN: begin
							if (leave_low) begin
								close_d = 1'b1;
								angle_d = cfg.close_angle;
								phase_d = CLOSING;
								tip_d   = '0;
								entered = 1'b1;
							end
						end
						default: begin
							if (servo_done_q || ms_tip >= {4'b0000, cfg.settle_time_ms}) begin
								phase_d = CLOSED;
								tip_d   = '0;
								entered = 1'b1;
							end
						end
					endcase
					// Watchdog: a fresh phase has zero elapsed time, so only a held
					// motion phase can overrun
					if (!entered && (phase_q == OPENING || phase_q == CLOSING) &&
					    ms_tip > wd_limit) begin
						fault_d[FLT_SERVO] = 1'b1;
						close_d = 1'b1;
						angle_d = cfg.close_angle;
						if (phase_q != CLOSING) begin
							phase_d = CLOSING;
							tip_d   = '0;
						end
					end
					flags_d = fault_d;
				end
				MODE_SNAPSHOT: begin
					speed_d  = item.veh_speed;
					brake_d  = item.brake_on;
					enable_d = item.enable_in;
					ext_d    = item.external_fault_in;
					tss_d    = '0;
				end
				MODE_SERVO: servo_done_d = item.servo_reached;
				MODE_FORCE_CLOSE: begin
					close_d = 1'b1;
					angle_d = cfg.close_angle;
					phase_d = CLOSING;
					tip_d   = '0;
				end
				MODE_DISABLE: begin
					fault_d[FLT_DISABLED] = 1'b1;
					close_d = 1'b1;
					angle_d = cfg.close_angle;
					phase_d = CLOSING;
					tip_d   = '0;
				end
				MODE_CLEAR: fault_d = '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= CLOSED;
			tip_q        <= '0;
			tss_q        <= '0;
			fault_q      <= '0;
			servo_done_q <= 1'b0;
			speed_q      <= '0;
			brake_q      <= 1'b0;
			enable_q     <= 1'b0;
			ext_q        <= 1'b0;
			open_q       <= 1'b0;
			close_q      <= 1'b0;
			angle_q      <= '0;
			flags_q      <= '0;
		end else begin
			phase_q      <= phase_d;
			tip_q        <= tip_d;
			tss_q        <= tss_d;
			fault_q      <= fault_d;
			servo_done_q <= servo_done_d;
			speed_q      <= speed_d;
			brake_q      <= brake_d;
			enable_q     <= enable_d;
			ext_q        <= ext_d;
			open_q       <= open_d;
			close_q      <= close_d;
			angle_q      <= angle_d;
			flags_q      <= flags_d;
		end
	end

	assign res = '{open_cmd:     open_q,
	               close_cmd:    close_q,
	               target_angle: angle_q,
	               fault_latch:  flags_q,
	               fsm_state:    phase_q};

endmodule

// ===== rtl/aero_flap_actuator_fsm.sv =====
// Top level of the flap actuator controller: input stage, core and result handshake.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one event word: mode plus the
//   snapshot fields and the servo report bit. Fields a mode does not use are
//   ignored.
// - Output channel (out_valid/out_ready) returns exactly one result word per
//   event: open/close commands, target angle, latched fault flags, phase.
// - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   one of six registers; cfg_ready is always high, unknown indexes are
//   dropped. Write only while no event is in flight.
// - Path: an accepted event is held in the input register, then one update
//   of the phase logic writes it into the result record.
// - Throughput: one event per clock while out_ready is high; the update is a
//   single pass of the phase logic, two 16x10 shift-adds and a few compares.
// - Receiver stall: the result word holds, the input register fills, and
//   in_ready drops after one more accepted word; nothing is lost.
// - Reset (arst_n low): phase closed, counters, faults, held snapshot and
//   result record cleared, config registers zero, no word valid.
module aero_flap_actuator_fsm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   mode,
	input  logic [7:0]                   veh_speed,
	input  logic                         brake_on,
	input  logic                         enable_in,
	input  logic                         external_fault_in,
	input  logic                         servo_reached,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         open_cmd,
	output logic                         close_cmd,
	output logic [7:0]                   target_angle,
	output logic [2:0]                   fault_latch,
	output logic [1:0]                   fsm_state,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [afa_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [afa_pkg::CfgDataW-1:0] cfg_data
);
	import afa_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;
	result_t res;

	afa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance when the result slot is free or is being taken this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{mode:              mode,
			             veh_speed:         veh_speed,
			             brake_on:          brake_on,
			             enable_in:         enable_in,
			             external_fault_in: external_fault_in,
			             servo_reached:     servo_reached};
		end
	end

	afa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid    = out_valid_q;
	assign open_cmd     = res.open_cmd;
	assign close_cmd    = res.close_cmd;
	assign target_angle = res.target_angle;
	assign fault_latch  = res.fault_latch;
	assign fsm_state    = res.fsm_state;

	// Input stalls only behind a held result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid_q && !out_ready && valid_s1))
		else $error("input stalled without a held result");

	// A result appears only from an event leaving the input register
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result word without an event");

	// An open command stands only while the flap is away from closed
	a_open_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res.open_cmd |-> (res.fsm_state != PH_CLOSED))
		else $error("open command while closed");

endmodule

// ===== tb/sv/tb_aero_flap_actuator_fsm.sv =====
// Testbench for the flap actuator controller: directed and random events against a predictor.
`timescale 1ns / 1ps

module tb_aero_flap_actuator_fsm;
	import afa_pkg::*;

	localparam int unsigned MS_PER_TICK  = 10;
	localparam int unsigned WD_FACTOR    = 2;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_OFF     = 64;

	localparam logic [2:0]         MODE_SPARE_A  = 3'd6;
	localparam logic [2:0]         MODE_SPARE_B  = 3'd7;
	localparam logic [CfgIdxW-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_UNUSED_HI = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [2:0]          mode;
	logic [7:0]          veh_speed;
	logic                brake_on;
	logic                enable_in;
	logic                external_fault_in;
	logic                servo_reached;
	logic                out_valid;
	logic                out_ready;
	logic                open_cmd;
	logic                close_cmd;
	logic [7:0]          target_angle;
	logic [2:0]          fault_latch;
	logic [1:0]          fsm_state;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int idle_max;
	int hold_off_cycles;
	int quiet_cycles;

	aero_flap_actuator_fsm dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.veh_speed         (veh_speed),
		.brake_on          (brake_on),
		.enable_in         (enable_in),
		.external_fault_in (external_fault_in),
		.servo_reached     (servo_reached),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.open_cmd          (open_cmd),
		.close_cmd         (close_cmd),
		.target_angle      (target_angle),
		.fault_latch       (fault_latch),
		.fsm_state         (fsm_state),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// Flap controller predictor plus the queue of result words still owed by the block.
	class flap_scoreboard;
		cfg_t        regs;
		logic [1:0]  cur_phase;
		logic [15:0] phase_ticks;
		logic [15:0] snap_ticks;
		logic [2:0]  faults;
		bit          servo_done;
		logic [7:0]  held_speed;
		bit          held_brake;
		bit          held_enable;
		bit          held_ext;
		result_t     rec;
		result_t     owed_q[$];
		int          errors;

		function new();
			regs        = '0;
			cur_phase   = PH_CLOSED;
			phase_ticks = '0;
			snap_ticks  = '0;
			faults      = '0;
			servo_done  = 0;
			held_speed  = '0;
			held_brake  = 0;
			held_enable = 0;
			held_ext    = 0;
			rec         = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_OPEN_SPEED:    regs.open_speed      = data[7:0];
				REG_CLOSE_SPEED:   regs.close_speed     = data[7:0];
				REG_OPEN_ANGLE:    regs.open_angle      = data[7:0];
				REG_CLOSE_ANGLE:   regs.close_angle     = data[7:0];
				REG_SETTLE_TIME:   regs.settle_time_ms  = data;
				REG_INPUT_TIMEOUT: regs.snap_timeout_ms = data;
				default: ;
			endcase
		endfunction

		function void enter_phase(logic [1:0] p);
			cur_phase   = p;
			phase_ticks = '0;
			if (p == PH_OPENING)
				rec.target_angle = regs.open_angle;
			else if (p == PH_CLOSING)
				rec.target_angle = regs.close_angle;
		endfunction

		function void start_closing();
			rec.close_cmd = 1'b1;
			enter_phase(PH_CLOSING);
		endfunction

		function void note_event(item_t ev);
			logic [31:0] ms;
			logic [31:0] wd_limit;
			bit          must_close;
			bit          leave_low;
			case (ev.mode)
				MODE_TICK: begin
					rec.open_cmd  = 1'b0;
					rec.close_cmd = 1'b0;
					// saturate, never wrap
					if (phase_ticks != 16'hFFFF)
						phase_ticks++;
					if (snap_ticks != 16'hFFFF)
						snap_ticks++;
					faults[FLT_TIMEOUT] = (32'(snap_ticks) * MS_PER_TICK) >
						32'(regs.snap_timeout_ms);
					faults[FLT_DISABLED] = !held_enable;
					must_close = faults[FLT_TIMEOUT] || faults[FLT_DISABLED] || held_ext ||
						!held_enable;
					leave_low = must_close || held_brake || (held_speed < regs.close_speed);
					ms = 32'(phase_ticks) * MS_PER_TICK;
					case (cur_phase)
						PH_CLOSED: begin
							if (!must_close && !held_brake && held_speed > regs.open_speed) begin
								rec.open_cmd = 1'b1;
								enter_phase(PH_OPENING);
							end
						end
						PH_OPENING: begin
							if (leave_low)
								start_closing();
							else if (servo_done || ms >= 32'(regs.settle_time_ms))
								enter_phase(PH_OPEN);
						end
						PH_OPEN: begin
							if (leave_low)
								start_closing();
						end
						default: begin
							if (servo_done || ms >= 32'(regs.settle_time_ms))
								enter_phase(PH_CLOSED);
						end
					endcase
					// watchdog sees the timer after any phase change above
					ms = 32'(phase_ticks) * MS_PER_TICK;
					wd_limit = (32'(regs.settle_time_ms) * WD_FACTOR) & 32'h0000_FFFF;
					if ((cur_phase == PH_OPENING || cur_phase == PH_CLOSING) && ms > wd_limit) begin
						faults[FLT_SERVO] = 1'b1;
						rec.close_cmd     = 1'b1;
						rec.target_angle  = regs.close_angle;
						if (cur_phase != PH_CLOSING)
							enter_phase(PH_CLOSING);
					end
					rec.fault_latch = faults;
				end
				MODE_SNAPSHOT: begin
					held_speed  = ev.veh_speed;
					held_brake  = ev.brake_on;
					held_enable = ev.enable_in;
					held_ext    = ev.external_fault_in;
					snap_ticks  = '0;
				end
				MODE_SERVO:       servo_done = ev.servo_reached;
				MODE_FORCE_CLOSE: start_closing();
				MODE_DISABLE: begin
					faults[FLT_DISABLED] = 1'b1;
					start_closing();
				end
				MODE_CLEAR:       faults = '0;
				default: ;
			endcase
			rec.fsm_state = cur_phase;
			owed_q.push_back(rec);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed_q.size() == 0) begin
				$error("result word with no event pending");
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (got.open_cmd !== want.open_cmd) begin
				$error("open_cmd: expected %0d, got %0d", want.open_cmd, got.open_cmd);
				errors++;
			end
			if (got.close_cmd !== want.close_cmd) begin
				$error("close_cmd: expected %0d, got %0d", want.close_cmd, got.close_cmd);
				errors++;
			end
			if (got.target_angle !== want.target_angle) begin
				$error("target_angle: expected %0d, got %0d", want.target_angle,
					got.target_angle);
				errors++;
			end
			if (got.fault_latch !== want.fault_latch) begin
				$error("fault_latch: expected %0d, got %0d", want.fault_latch, got.fault_latch);
				errors++;
			end
			if (got.fsm_state !== want.fsm_state) begin
				$error("fsm_state: expected %0d, got %0d", want.fsm_state, got.fsm_state);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	flap_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({open_cmd, close_cmd, target_angle, fault_latch, fsm_state});
	end

	// End the run when no channel moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int n;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = $urandom_range(0, idle_max);
			if (hold_off_cycles > 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
			end
			repeat (n) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	function automatic item_t mk_event(logic [2:0] m, logic [7:0] spd, logic brk, logic en,
			logic ext, logic srv);
		item_t e;
		e.mode              = m;
		e.veh_speed         = spd;
		e.brake_on          = brk;
		e.enable_in         = en;
		e.external_fault_in = ext;
		e.servo_reached     = srv;
		return e;
	endfunction

	// Mostly well-formed traffic: frequent ticks, snapshots that usually permit opening.
	function automatic item_t draw_event(int noise_pct);
		item_t e;
		int    r;
		e = mk_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		r = $urandom_range(0, 99);
		if (r < noise_pct)
			return e;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			e.mode = MODE_TICK;
		end else if (r < 75) begin
			e.mode              = MODE_SNAPSHOT;
			e.enable_in         = ($urandom_range(0, 9) != 0);
			e.external_fault_in = ($urandom_range(0, 9) == 0);
			e.brake_on          = ($urandom_range(0, 7) == 0);
		end else if (r < 87) begin
			e.mode = MODE_SERVO;
		end else if (r < 91) begin
			e.mode = MODE_FORCE_CLOSE;
		end else if (r < 94) begin
			e.mode = MODE_DISABLE;
		end else begin
			e.mode = MODE_CLEAR;
		end
		return e;
	endfunction

	function automatic cfg_t mk_cfg(logic [7:0] os, logic [7:0] cs, logic [7:0] oa,
			logic [7:0] ca, logic [15:0] st, logic [15:0] it);
		cfg_t c;
		c.open_speed      = os;
		c.close_speed     = cs;
		c.open_angle      = oa;
		c.close_angle     = ca;
		c.settle_time_ms  = st;
		c.snap_timeout_ms = it;
		return c;
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		int   r;
		c.open_speed  = 8'($urandom_range(0, 255));
		c.close_speed = 8'($urandom_range(0, c.open_speed));
		c.open_angle  = 8'($urandom_range(0, 180));
		c.close_angle = 8'($urandom_range(0, 180));
		r = $urandom_range(0, 9);
		if (r < 6)
			c.settle_time_ms = 16'($urandom_range(0, 200));
		else if (r < 8)
			c.settle_time_ms = 16'($urandom_range(32768, 33000));
		else
			c.settle_time_ms = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 9) < 7)
			c.snap_timeout_ms = 16'($urandom_range(100, 400));
		else
			c.snap_timeout_ms = 16'($urandom_range(0, 65535));
		return c;
	endfunction

	task automatic send_event(item_t ev);
		int gap;
		gap = $urandom_range(0, idle_max);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		mode              <= ev.mode;
		veh_speed         <= ev.veh_speed;
		brake_on          <= ev.brake_on;
		enable_in         <= ev.enable_in;
		external_fault_in <= ev.external_fault_in;
		servo_reached     <= ev.servo_reached;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_event(ev);
	endtask

	task automatic write_word(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Upper byte of the 8-bit registers carries junk that must be dropped.
	task automatic write_config(cfg_t c, bit with_spare);
		write_word(REG_OPEN_SPEED,    {8'($urandom), c.open_speed});
		write_word(REG_CLOSE_SPEED,   {8'($urandom), c.close_speed});
		write_word(REG_OPEN_ANGLE,    {8'($urandom), c.open_angle});
		write_word(REG_CLOSE_ANGLE,   {8'($urandom), c.close_angle});
		write_word(REG_SETTLE_TIME,   c.settle_time_ms);
		write_word(REG_INPUT_TIMEOUT, c.snap_timeout_ms);
		if (with_spare) begin
			write_word(REG_UNUSED_LO, 16'($urandom));
			write_word(REG_UNUSED_HI, 16'($urandom));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(cfg_t c, int count, int noise_pct);
		write_config(c, 1'b0);
		repeat (count) send_event(draw_event(noise_pct));
		end_burst();
	endtask

	initial begin
		cfg_t cfg_a;
		idle_max          = 6;
		hold_off_cycles   = 0;
		quiet_cycles      = 0;
		in_valid          <= 1'b0;
		mode              <= MODE_TICK;
		veh_speed         <= '0;
		brake_on          <= 1'b0;
		enable_in         <= 1'b0;
		external_fault_in <= 1'b0;
		servo_reached     <= 1'b0;
		cfg_valid         <= 1'b0;
		cfg_index         <= REG_OPEN_SPEED;
		cfg_data          <= '0;
		arst_n            <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all registers still zero: the timeout trips on the first tick
		send_event(mk_event(MODE_SPARE_B, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
		send_event(mk_event(MODE_SPARE_A, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_CLEAR,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		end_burst();

		cfg_a = mk_cfg(8'd50, 8'd30, 8'd120, 8'd10, 16'd30, 16'd200);
		write_config(cfg_a, 1'b1);
		// open, settle by servo report, close on brake
		send_event(mk_event(MODE_SNAPSHOT,    8'd255, 1'b0, 1'b1, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_SERVO,       8'd0,   1'b0, 1'b0, 1'b0, 1'b1));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_SNAPSHOT,    8'd40,  1'b1, 1'b1, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_SERVO,       8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		// driver disabled with an external fault, then forced motions and a clear
		send_event(mk_event(MODE_SNAPSHOT,    8'd0,   1'b0, 1'b0, 1'b1, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_DISABLE,     8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_FORCE_CLOSE, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_CLEAR,       8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(MODE_SNAPSHOT,    8'd255, 1'b1, 1'b1, 1'b1, 1'b1));
		send_event(mk_event(MODE_TICK,        8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
		end_burst();

		// fill the block while the result side holds off
		hold_off_cycles = HOLD_OFF;
		run_random(cfg_a, 130, 10);
		run_random(mk_cfg(8'd0, 8'd255, 8'd180, 8'd0, 16'd0, 16'd65535), 110, 10);
		run_random(mk_cfg(8'd255, 8'd0, 8'd0, 8'd180, 16'd65535, 16'd0), 60, 10);
		// watchdog limit wraps to zero here
		run_random(mk_cfg(8'd0, 8'd0, 8'd180, 8'd180, 16'd32768, 16'd300), 110, 10);
		idle_max = 0;
		run_random(rand_cfg(), 110, 15);
		idle_max = 6;
		run_random(rand_cfg(), 110, 10);
		run_random(rand_cfg(), 110, 20);

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
